FILE: rtl/xdm_pkg.sv
`default_nettype none
package xdm_pkg;

  // APB address width and register indexes (byte address = 4 * index)
  localparam int unsigned APB_AW = 4;
  localparam logic [1:0] REG_MOVE_GAIN   = 2'd0;
  localparam logic [1:0] REG_STRAFE_GAIN = 2'd1;
  localparam logic [1:0] REG_TURN_GAIN   = 2'd2;

  localparam int unsigned GAIN_W = 10;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 10'd256;

  // pending turn counter width, holds well over the largest turn plus spill
  localparam int unsigned TURN_W = 12;

  // how many units a wheel takes in one step
  typedef enum logic [1:0] {
    ADD_NONE = 2'd0,
    ADD_ONE  = 2'd1,
    ADD_TWO  = 2'd2
  } add_e;

  // decision of one turn step for one side
  typedef struct packed {
    add_e front_add;
    add_e rear_add;
    logic spill;
  } step_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_BASE,
    ST_LEFT,
    ST_RIGHT,
    ST_LEFT2,
    ST_DONE
  } state_e;

endpackage
`default_nettype wire

FILE: rtl/xdm_step.sv
`default_nettype none
// One turn unit for one side: decides where the unit lands, or whether it spills.
module xdm_step #(
  parameter int MotorLimit = 127,
  parameter int WheelW     = 9
) (
  input  wire logic                     neg_i,
  input  wire logic signed [WheelW-1:0] front_i,
  input  wire logic signed [WheelW-1:0] rear_i,
  output xdm_pkg::step_t                ctl_o
);
  import xdm_pkg::*;

  localparam logic signed [WheelW-1:0] LimP = WheelW'(MotorLimit);
  localparam logic signed [WheelW-1:0] LimN = -LimP;

  logic signed [WheelW-1:0] u1, u2;
  logic signed [WheelW-1:0] f1, f2, r1, r2;
  logic fit_f1, fit_f2, fit_r1, fit_r2;

  // one and two units in the turn direction
  assign u1 = neg_i ? -WheelW'(1) : WheelW'(1);
  assign u2 = neg_i ? -WheelW'(2) : WheelW'(2);

  assign f1 = front_i + u1;
  assign f2 = front_i + u2;
  assign r1 = rear_i + u1;
  assign r2 = rear_i + u2;

  assign fit_f1 = (f1 <= LimP) && (f1 >= LimN);
  assign fit_f2 = (f2 <= LimP) && (f2 >= LimN);
  assign fit_r1 = (r1 <= LimP) && (r1 >= LimN);
  assign fit_r2 = (r2 <= LimP) && (r2 >= LimN);

  // placement priority: front, then rear or a second front unit; else rear alone
  always_comb begin
    ctl_o = '{front_add: ADD_NONE, rear_add: ADD_NONE, spill: 1'b0};
    if (fit_f1) begin
      ctl_o.front_add = ADD_ONE;
      if (fit_r1) begin
        ctl_o.rear_add = ADD_ONE;
      end else if (fit_f2) begin
        ctl_o.front_add = ADD_TWO;
      end
    end else if (fit_r2) begin
      ctl_o.rear_add = ADD_TWO;
    end else if (fit_r1) begin
      ctl_o.rear_add = ADD_ONE;
    end else begin
      ctl_o.spill = 1'b1;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/x_drive_mixer_turn_spill.sv
// X-drive mixer: one shared 8x10 multiplier forms the three scaled commands in
// turn, the saturated wheel bases are then built, then a single step unit places
// one turn unit per cycle over three passes (left, right, left).
// done_o is a one-cycle strobe after the last pass; busy holds through done, and a
// new transaction is accepted only once the block is back in idle.
// Reset clears the sequencer and sets all gains to 1.0; results cannot be stalled.
`default_nettype none
module x_drive_mixer_turn_spill #(
  parameter int MotorLimit = 127
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // command
  input  wire logic                        start,
  output      logic                        busy,
  input  wire logic signed [7:0]           move_cmd_i,
  input  wire logic signed [7:0]           strafe_cmd_i,
  input  wire logic signed [7:0]           turn_cmd_i,
  // result
  output      logic                        done_o,
  output      logic signed [7:0]           front_left_out_o,
  output      logic signed [7:0]           front_right_out_o,
  output      logic signed [7:0]           rear_left_out_o,
  output      logic signed [7:0]           rear_right_out_o,
  // configuration
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [xdm_pkg::APB_AW-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output      logic [31:0]                 prdata,
  output      logic                        pready
);
  import xdm_pkg::*;

  localparam int WheelW = $clog2(MotorLimit + 3) + 1;
  localparam int CmpW   = (WheelW > 13) ? WheelW + 1 : 14;
  localparam int ExtW   = (WheelW > 8) ? WheelW : 8;

  state_e state_q, state_d;

  logic [GAIN_W-1:0] move_gain_q, strafe_gain_q, turn_gain_q;
  logic              cfg_wr;

  logic signed [7:0] mc_q, mc_d, sc_q, sc_d, tc_q, tc_d;
  logic [1:0]        mcnt_q, mcnt_d;
  logic signed [18:0] mv_q, mv_d, st_q, st_d, p_q, p_d;

  logic signed [WheelW-1:0] fl_q, fl_d, fr_q, fr_d, rl_q, rl_d, rr_q, rr_d;
  logic signed [TURN_W-1:0] t_q, t_d, rt_q, rt_d, spill_q, spill_d;

  // shared multiplier
  logic signed [7:0]  mul_a;
  logic [GAIN_W-1:0]  mul_b;
  logic signed [18:0] prod;

  // base and turn split
  logic signed [19:0] sum_p, sum_m;
  logic [18:0]        pmag;
  logic [19:0]        half_sum;
  logic signed [TURN_W-1:0] lt;

  // step unit
  logic                     t_neg, t_zero, on_left;
  logic signed [WheelW-1:0] front_s, rear_s, u1, u2, front_n, rear_n;
  logic signed [TURN_W-1:0] ut;
  step_t                    step;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      move_gain_q   <= GAIN_RESET;
      strafe_gain_q <= GAIN_RESET;
      turn_gain_q   <= GAIN_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_MOVE_GAIN:   move_gain_q   <= pwdata[GAIN_W-1:0];
        REG_STRAFE_GAIN: strafe_gain_q <= pwdata[GAIN_W-1:0];
        REG_TURN_GAIN:   turn_gain_q   <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MOVE_GAIN:   prdata = {(32 - GAIN_W)'(0), move_gain_q};
      REG_STRAFE_GAIN: prdata = {(32 - GAIN_W)'(0), strafe_gain_q};
      REG_TURN_GAIN:   prdata = {(32 - GAIN_W)'(0), turn_gain_q};
      default:         prdata = '0;
    endcase
  end

  // ---------------- shared multiplier ----------------
  always_comb begin
    case (mcnt_q)
      2'd0: begin
        mul_a = mc_q;
        mul_b = move_gain_q;
      end
      2'd1: begin
        mul_a = sc_q;
        mul_b = strafe_gain_q;
      end
      default: begin
        mul_a = tc_q;
        mul_b = turn_gain_q;
      end
    endcase
  end

  assign prod = 19'(mul_a) * 19'($signed({1'b0, mul_b}));

  // ---------------- base sums and turn split ----------------
  function automatic logic signed [WheelW-1:0] wheel_base(input logic signed [19:0] num);
    logic [19:0]     mag;
    logic [CmpW-1:0] q;
    logic [CmpW-1:0] m;
    mag = num[19] ? 20'(-num) : 20'(num);
    q   = CmpW'(mag[19:8]);
    m   = (q > CmpW'(MotorLimit)) ? CmpW'(MotorLimit) : q;
    return num[19] ? -$signed(m[WheelW-1:0]) : $signed(m[WheelW-1:0]);
  endfunction

  assign sum_p    = 20'(mv_q) + 20'(st_q);
  assign sum_m    = 20'(mv_q) - 20'(st_q);
  assign pmag     = p_q[18] ? 19'(-p_q) : 19'(p_q);
  assign half_sum = 20'(pmag) + 20'd256;
  assign lt       = p_q[18] ? -$signed(TURN_W'(half_sum[19:9])) : $signed(TURN_W'(half_sum[19:9]));

  // ---------------- turn step unit ----------------
  assign on_left = (state_q == ST_LEFT) || (state_q == ST_LEFT2);
  assign front_s = on_left ? fl_q : fr_q;
  assign rear_s  = on_left ? rl_q : rr_q;
  assign t_neg   = t_q[TURN_W-1];
  assign t_zero  = (t_q == '0);
  assign ut      = t_neg ? -TURN_W'(1) : TURN_W'(1);
  assign u1      = t_neg ? -WheelW'(1) : WheelW'(1);
  assign u2      = t_neg ? -WheelW'(2) : WheelW'(2);

  xdm_step #(
    .MotorLimit (MotorLimit),
    .WheelW     (WheelW)
  ) u_step (
    .neg_i   (t_neg),
    .front_i (front_s),
    .rear_i  (rear_s),
    .ctl_o   (step)
  );

  always_comb begin
    case (step.front_add)
      ADD_ONE: front_n = front_s + u1;
      ADD_TWO: front_n = front_s + u2;
      default: front_n = front_s;
    endcase
    case (step.rear_add)
      ADD_ONE: rear_n = rear_s + u1;
      ADD_TWO: rear_n = rear_s + u2;
      default: rear_n = rear_s;
    endcase
  end

  // ---------------- sequencer: next state ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (start) state_d = ST_MUL;
      ST_MUL:   if (mcnt_q == 2'd2) state_d = ST_BASE;
      ST_BASE:  state_d = ST_LEFT;
      ST_LEFT:  if (t_zero) state_d = ST_RIGHT;
      ST_RIGHT: if (t_zero) state_d = ST_LEFT2;
      ST_LEFT2: if (t_zero) state_d = ST_DONE;
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // ---------------- sequencer: outputs ----------------
  always_comb begin
    busy   = 1'b1;
    done_o = 1'b0;
    case (state_q)
      ST_IDLE: busy = 1'b0;
      ST_DONE: done_o = 1'b1;
      default: ;
    endcase
  end

  // ---------------- datapath ----------------
  always_comb begin
    mc_d    = mc_q;
    sc_d    = sc_q;
    tc_d    = tc_q;
    mcnt_d  = mcnt_q;
    mv_d    = mv_q;
    st_d    = st_q;
    p_d     = p_q;
    fl_d    = fl_q;
    fr_d    = fr_q;
    rl_d    = rl_q;
    rr_d    = rr_q;
    t_d     = t_q;
    rt_d    = rt_q;
    spill_d = spill_q;
    case (state_q)
      ST_IDLE: begin
        mcnt_d = 2'd0;
        if (start) begin
          mc_d = move_cmd_i;
          sc_d = strafe_cmd_i;
          tc_d = turn_cmd_i;
        end
      end
      ST_MUL: begin
        mcnt_d = mcnt_q + 2'd1;
        case (mcnt_q)
          2'd0:    mv_d = prod;
          2'd1:    st_d = prod;
          default: p_d  = prod;
        endcase
      end
      ST_BASE: begin
        fl_d    = wheel_base(sum_p);
        rr_d    = wheel_base(sum_p);
        fr_d    = wheel_base(sum_m);
        rl_d    = wheel_base(sum_m);
        t_d     = lt;
        rt_d    = -lt;
        spill_d = '0;
      end
      ST_LEFT, ST_RIGHT, ST_LEFT2: begin
        if (!t_zero) begin
          t_d = t_q - ut;
          if (step.spill) spill_d = spill_q - ut;
          if (on_left) begin
            fl_d = front_n;
            rl_d = rear_n;
          end else begin
            fr_d = front_n;
            rr_d = rear_n;
          end
        end else if (state_q == ST_LEFT) begin
          t_d     = rt_q + spill_q;
          spill_d = '0;
        end else if (state_q == ST_RIGHT) begin
          t_d     = spill_q;
          spill_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mcnt_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      mcnt_q  <= mcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mc_q    <= mc_d;
    sc_q    <= sc_d;
    tc_q    <= tc_d;
    mv_q    <= mv_d;
    st_q    <= st_d;
    p_q     <= p_d;
    fl_q    <= fl_d;
    fr_q    <= fr_d;
    rl_q    <= rl_d;
    rr_q    <= rr_d;
    t_q     <= t_d;
    rt_q    <= rt_d;
    spill_q <= spill_d;
  end

  // ---------------- result ports ----------------
  logic signed [ExtW-1:0] fl_ext, fr_ext, rl_ext, rr_ext;
  assign fl_ext = ExtW'(fl_q);
  assign fr_ext = ExtW'(fr_q);
  assign rl_ext = ExtW'(rl_q);
  assign rr_ext = ExtW'(rr_q);

  assign front_left_out_o  = fl_ext[7:0];
  assign front_right_out_o = fr_ext[7:0];
  assign rear_left_out_o   = rl_ext[7:0];
  assign rear_right_out_o  = rr_ext[7:0];

`ifndef SYNTHESIS
  // an accepted transaction makes the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // the result strobe lasts exactly one cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done_o held longer than one cycle");

  // all turn units are placed or spilled before the result is shown
  a_done_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (t_q == '0))
    else $error("result shown with turn units pending");

  // the side being stepped always stays inside the motor limit
  a_step_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_LEFT) || (state_q == ST_RIGHT) || (state_q == ST_LEFT2)) |->
      ((front_s <= WheelW'(MotorLimit)) && (front_s >= -WheelW'(MotorLimit)) &&
       (rear_s <= WheelW'(MotorLimit)) && (rear_s >= -WheelW'(MotorLimit))))
    else $error("wheel command outside motor limit during turn step");
`endif

endmodule
`default_nettype wire
